/* hdl/bfha_pkg.sv */
// package for the best-fit heap allocator
// holds payload structs, controller state enum, command/status structs and constants
package bfha_pkg;

  localparam int unsigned NumNodesDef  = 64;
  localparam int unsigned HeapBytesDef = 65536;
  localparam logic [6:0]  HdrReset     = 7'd16;

  localparam logic KindAlloc   = 1'b0;
  localparam logic KindRelease = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoRoom  = 2'd1;
  localparam logic [1:0] StBadAddr = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
  } req_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
    logic [16:0] heap_break;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_WT,
    S_WALK_EV,
    S_ALLOC_DEC,
    S_SPLIT_NXT,
    S_APPEND,
    S_REL_RD_N,
    S_REL_WT_N,
    S_REL_EV_N,
    S_REL_RD_P,
    S_REL_WT_P,
    S_REL_EV_P,
    S_REL_RD_C,
    S_REL_WT_C,
    S_REL_EV_C,
    S_UNLINK_RD,
    S_UNLINK_WT,
    S_UNLINK_EV,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic   start;
    state_e st;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic hit;
    logic cond_a;
    logic cond_b;
    logic unlink_after;
  } sts_t;

endpackage

/* hdl/bfha_ram.sv */
// generic single-port-write, single-read ram with registered read
// no package dependency
module bfha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/bfha_ctrl.sv */
// controller state machine for the allocator
// depends on bfha_pkg
module bfha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic          req_kind_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output bfha_pkg::cmd_t cmd_o,
  input  bfha_pkg::sts_t sts_i
);
  import bfha_pkg::*;

  state_e state_q, state_d;
  logic   rvalid_q, rvalid_d;
  logic   is_rel_q, is_rel_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rvalid_q <= 1'b0;
      is_rel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      is_rel_q <= is_rel_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    is_rel_d = is_rel_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && !rvalid_q) begin
          state_d  = S_WALK_RD;
          is_rel_d = (req_kind_i == KindRelease);
        end
      end
      S_WALK_RD: state_d = S_WALK_WT;
      S_WALK_WT: state_d = S_WALK_EV;
      S_WALK_EV: begin
        if (sts_i.walk_done) begin
          if (is_rel_q) state_d = sts_i.hit ? S_REL_RD_N : S_RESP;
          else          state_d = S_ALLOC_DEC;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_ALLOC_DEC: begin
        // cond_a: split needed; cond_b: append needed
        if (sts_i.cond_a)      state_d = S_SPLIT_NXT;
        else if (sts_i.cond_b) state_d = S_APPEND;
        else                   state_d = S_RESP;
      end
      S_SPLIT_NXT: state_d = S_RESP;
      S_APPEND:    state_d = S_RESP;
      S_REL_RD_N:  state_d = S_REL_WT_N;
      S_REL_WT_N:  state_d = S_REL_EV_N;
      S_REL_EV_N:  state_d = sts_i.cond_a ? S_UNLINK_RD : S_REL_RD_P;
      S_REL_RD_P:  state_d = S_REL_WT_P;
      S_REL_WT_P:  state_d = S_REL_EV_P;
      S_REL_EV_P:  state_d = sts_i.cond_a ? S_UNLINK_RD : S_REL_RD_C;
      S_REL_RD_C:  state_d = S_REL_WT_C;
      S_REL_WT_C:  state_d = S_REL_EV_C;
      S_REL_EV_C:  state_d = sts_i.cond_a ? S_UNLINK_RD : S_RESP;
      S_UNLINK_RD: state_d = S_UNLINK_WT;
      S_UNLINK_WT: state_d = S_UNLINK_EV;
      S_UNLINK_EV: begin
        // unlink_after says which check follows this unlink
        if (!sts_i.unlink_after)  state_d = S_REL_RD_P;
        else if (sts_i.cond_b)    state_d = S_REL_RD_C;
        else                      state_d = S_RESP;
      end
      S_RESP:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rvalid_d = rvalid_q;
    if (rvalid_q && rsp_ready_i) rvalid_d = 1'b0;
    if (state_q == S_RESP)       rvalid_d = 1'b1;
    req_ready_o = (state_q == S_IDLE) && !rvalid_q;
    cmd_o.start = req_valid_i && req_ready_o;
    cmd_o.st    = state_q;
    rsp_valid_o = rvalid_q;
  end

endmodule

/* hdl/bfha_dp.sv */
// datapath: node rams, list registers, walk and update logic
// depends on bfha_pkg and bfha_ram
module bfha_dp #(
  parameter int unsigned NumNodes  = bfha_pkg::NumNodesDef,
  parameter int unsigned HeapBytes = bfha_pkg::HeapBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [6:0]     cfg_data_i,
  input  bfha_pkg::req_t req_i,
  input  bfha_pkg::cmd_t cmd_i,
  output bfha_pkg::sts_t sts_o,
  output bfha_pkg::rsp_t rsp_o
);
  import bfha_pkg::*;

  localparam int unsigned IW = $clog2(NumNodes);
  localparam int unsigned PW = IW + 1;
  localparam logic [PW-1:0] Nil = PW'(NumNodes);
  localparam logic [17:0] HeapLim = 18'(HeapBytes > 131071 ? 131071 : HeapBytes);

  // size rams hold 17 bits; values above stay within 17 bits for the field range
  logic [IW-1:0] raddr;
  logic [16:0]   rsize;
  logic          rused;
  logic [PW-1:0] rnext, rprev;

  // read-modify-write via field enables over per-field rams
  logic [16:0] sz_wd; logic us_wd; logic [PW-1:0] nx_wd, pv_wd;
  logic [IW-1:0] sz_wa, us_wa, nx_wa, pv_wa;
  logic sz_we, us_we, nx_we, pv_we;

  bfha_ram #(.Width(17), .Depth(NumNodes)) u_size (
    .clk_i, .we_i(sz_we), .waddr_i(sz_wa), .wdata_i(sz_wd), .raddr_i(raddr), .rdata_o(rsize));
  bfha_ram #(.Width(1), .Depth(NumNodes)) u_used (
    .clk_i, .we_i(us_we), .waddr_i(us_wa), .wdata_i(us_wd), .raddr_i(raddr), .rdata_o(rused));
  bfha_ram #(.Width(PW), .Depth(NumNodes)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(raddr), .rdata_o(rnext));
  bfha_ram #(.Width(PW), .Depth(NumNodes)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(raddr), .rdata_o(rprev));

  // registers
  logic [6:0]        hdr_q;
  logic [NumNodes-1:0] taken_q, taken_d;
  logic [PW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [17:0]       brk_q, brk_d;
  logic [PW-1:0]     cur_q, cur_d;
  logic [IW:0]       cnt_q, cnt_d;
  logic [17:0]       off_q, off_d;
  logic [PW-1:0]     best_q, best_d, exact_q, exact_d;
  logic [16:0]       bsz_q, bsz_d;
  logic [17:0]       boff_q, boff_d, eoff_q, eoff_d;
  logic [PW-1:0]     bnext_q, bnext_d;
  logic [PW-1:0]     ci_q, ci_d;           // current release block
  logic [16:0]       csz_q, csz_d;
  logic [PW-1:0]     cnext_q, cnext_d, cprev_q, cprev_d;
  logic [PW-1:0]     ui_q, ui_d;           // block being unlinked
  logic              uphase_q, uphase_d;   // 0 next merge, 1 prev merge or trim
  logic              cond_a_q, cond_a_d, cond_b_q, cond_b_d;
  logic [1:0]        stat_q, stat_d;
  logic [15:0]       paddr_q, paddr_d;
  logic [16:0]       need_q, need_d;
  logic [15:0]       rela_q;
  logic [PW-1:0]     free_q, free_d;
  logic              spare_q, spare_d;

  // first free node
  logic [PW-1:0] first_free;
  always_comb begin
    first_free = Nil;
    for (int k = NumNodes - 1; k >= 0; k--) begin
      if (!taken_q[k]) first_free = PW'(k);
    end
  end

  // configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= HdrReset;
      taken_q <= '0;
      head_q  <= Nil;
      tail_q  <= Nil;
      brk_q   <= '0;
    end else begin
      if (cfg_valid_i) hdr_q <= cfg_data_i;
      taken_q <= taken_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      brk_q   <= brk_d;
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; cnt_q <= cnt_d; off_q <= off_d;
    best_q <= best_d; exact_q <= exact_d; bsz_q <= bsz_d;
    boff_q <= boff_d; eoff_q <= eoff_d; bnext_q <= bnext_d;
    ci_q <= ci_d; csz_q <= csz_d; cnext_q <= cnext_d; cprev_q <= cprev_d;
    ui_q <= ui_d; uphase_q <= uphase_d; cond_a_q <= cond_a_d; cond_b_q <= cond_b_d;
    stat_q <= stat_d; paddr_q <= paddr_d; need_q <= need_d;
    free_q <= free_d; spare_q <= spare_d;
    if (cmd_i.start) begin
      rela_q <= req_i.release_address;
    end
  end

  logic [17:0] off_hdr;
  logic        walk_end;
  assign off_hdr  = off_q + 18'(hdr_q);
  assign walk_end = (cur_q == Nil) || (cnt_q == (IW+1)'(NumNodes));

  always_comb begin
    taken_d = taken_q; head_d = head_q; tail_d = tail_q; brk_d = brk_q;
    cur_d = cur_q; cnt_d = cnt_q; off_d = off_q;
    best_d = best_q; exact_d = exact_q; bsz_d = bsz_q;
    boff_d = boff_q; eoff_d = eoff_q; bnext_d = bnext_q;
    ci_d = ci_q; csz_d = csz_q; cnext_d = cnext_q; cprev_d = cprev_q;
    ui_d = ui_q; uphase_d = uphase_q; cond_a_d = cond_a_q; cond_b_d = cond_b_q;
    stat_d = stat_q; paddr_d = paddr_q; need_d = need_q;
    free_d = first_free; spare_d = (first_free != Nil);
    raddr = cur_q[IW-1:0];
    sz_we = 1'b0; us_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
    sz_wa = '0; us_wa = '0; nx_wa = '0; pv_wa = '0;
    sz_wd = '0; us_wd = 1'b0; nx_wd = '0; pv_wd = '0;
    sts_o = '0;

    if (cmd_i.start) begin
      cur_d   = head_q;
      cnt_d   = '0;
      off_d   = '0;
      best_d  = Nil;
      exact_d = Nil;
      stat_d  = StOk;
      paddr_d = '0;
      need_d  = 17'(req_i.request_bytes) + 17'(hdr_q);
    end

    case (cmd_i.st)
      S_WALK_RD, S_WALK_WT: raddr = cur_q[IW-1:0];
      S_WALK_EV: begin
        sts_o.walk_done = walk_end;
        if (!walk_end) begin
          // release match ends the walk
          if (rused && off_hdr == 18'(rela_q) && cond_b_q) begin
            sts_o.walk_done = 1'b1;
            sts_o.hit       = 1'b1;
            ci_d   = cur_q;
            csz_d  = rsize;
            cnext_d = rnext;
            cprev_d = rprev;
          end
          if (!rused) begin
            if (exact_q == Nil && rsize == need_q) begin
              exact_d = cur_q; eoff_d = off_q;
            end
            if (rsize >= need_q && (best_q == Nil || rsize < bsz_q)) begin
              best_d = cur_q; boff_d = off_q; bsz_d = rsize; bnext_d = rnext;
            end
          end
          off_d = off_q + 18'(rsize);
          cur_d = rnext;
          cnt_d = cnt_q + (IW+1)'(1);
        end
        if (walk_end && cond_b_q) stat_d = StBadAddr;
      end
      S_ALLOC_DEC: begin
        if (exact_q != Nil) begin
          if (eoff_q + 18'(hdr_q) > 18'hFFFF) stat_d = StNoRoom;
          else begin
            us_we = 1'b1; us_wa = exact_q[IW-1:0]; us_wd = 1'b1;
            paddr_d = 16'(eoff_q + 18'(hdr_q));
          end
        end else if (best_q != Nil) begin
          if (boff_q + 18'(hdr_q) > 18'hFFFF) stat_d = StNoRoom;
          else begin
            us_we = 1'b1; us_wa = best_q[IW-1:0]; us_wd = 1'b1;
            paddr_d = 16'(boff_q + 18'(hdr_q));
            if ((bsz_q - need_q) > 17'(hdr_q) && spare_q) begin
              sts_o.cond_a = 1'b1;
              taken_d[free_q[IW-1:0]] = 1'b1;
              sz_we = 1'b1; sz_wa = free_q[IW-1:0]; sz_wd = bsz_q - need_q;
              nx_we = 1'b1; nx_wa = free_q[IW-1:0]; nx_wd = bnext_q;
              pv_we = 1'b1; pv_wa = free_q[IW-1:0]; pv_wd = best_q;
              ui_d = free_q;
            end
          end
        end else begin
          if (brk_q + 18'(need_q) > HeapLim || brk_q + 18'(hdr_q) > 18'hFFFF || !spare_q)
            stat_d = StNoRoom;
          else begin
            sts_o.cond_b = 1'b1;
            ui_d = free_q;
            taken_d[free_q[IW-1:0]] = 1'b1;
            sz_we = 1'b1; sz_wa = free_q[IW-1:0]; sz_wd = need_q;
            nx_we = 1'b1; nx_wa = free_q[IW-1:0]; nx_wd = Nil;
            pv_we = 1'b1; pv_wa = free_q[IW-1:0]; pv_wd = tail_q;
            paddr_d = 16'(brk_q + 18'(hdr_q));
          end
        end
      end
      S_SPLIT_NXT: begin
        // link the split remainder in after the best block
        us_we = 1'b1; us_wa = ui_q[IW-1:0]; us_wd = 1'b0;
        nx_we = 1'b1; nx_wa = best_q[IW-1:0]; nx_wd = ui_q;
        sz_we = 1'b1; sz_wa = best_q[IW-1:0]; sz_wd = need_q;
        if (bnext_q != Nil) begin
          pv_we = 1'b1; pv_wa = bnext_q[IW-1:0]; pv_wd = ui_q;
        end else tail_d = ui_q;
      end
      S_APPEND: begin
        us_we = 1'b1; us_wa = ui_q[IW-1:0]; us_wd = 1'b1;
        if (tail_q != Nil) begin
          nx_we = 1'b1; nx_wa = tail_q[IW-1:0]; nx_wd = ui_q;
        end else head_d = ui_q;
        tail_d = ui_q;
        brk_d  = brk_q + 18'(need_q);
      end
      S_REL_RD_N, S_REL_WT_N: begin
        raddr = cnext_q[IW-1:0];
        if (cmd_i.st == S_REL_RD_N) begin
          us_we = 1'b1; us_wa = ci_q[IW-1:0]; us_wd = 1'b0;
        end
      end
      S_REL_EV_N: begin
        raddr = cnext_q[IW-1:0];
        if (cnext_q != Nil && !rused) begin
          sts_o.cond_a = 1'b1;
          csz_d = csz_q + rsize;
          sz_we = 1'b1; sz_wa = ci_q[IW-1:0]; sz_wd = csz_q + rsize;
          ui_d = cnext_q; uphase_d = 1'b0;
        end
      end
      S_REL_RD_P, S_REL_WT_P: raddr = cprev_q[IW-1:0];
      S_REL_EV_P: begin
        raddr = cprev_q[IW-1:0];
        if (cprev_q != Nil && !rused) begin
          sts_o.cond_a = 1'b1;
          sz_we = 1'b1; sz_wa = cprev_q[IW-1:0]; sz_wd = rsize + csz_q;
          ui_d = ci_q; uphase_d = 1'b1;
          ci_d = cprev_q; csz_d = rsize + csz_q;
        end
      end
      S_REL_RD_C, S_REL_WT_C: raddr = ci_q[IW-1:0];
      S_REL_EV_C: begin
        raddr = ci_q[IW-1:0];
        if (rnext == Nil) begin
          sts_o.cond_a = 1'b1;
          brk_d = brk_q - 18'(rsize);
          ui_d = ci_q; uphase_d = 1'b1; cond_a_d = 1'b1;
        end
      end
      S_UNLINK_RD, S_UNLINK_WT: raddr = ui_q[IW-1:0];
      S_UNLINK_EV: begin
        raddr = ui_q[IW-1:0];
        sts_o.unlink_after = uphase_q;
        sts_o.cond_b       = !cond_a_q;
        taken_d[ui_q[IW-1:0]] = 1'b0;
        if (rprev != Nil) begin
          nx_we = 1'b1; nx_wa = rprev[IW-1:0]; nx_wd = rnext;
        end else head_d = rnext;
        if (rnext != Nil) begin
          pv_we = 1'b1; pv_wa = rnext[IW-1:0]; pv_wd = rprev;
        end else tail_d = rprev;
        // keep cached links of the live block in step
        if (ci_q != ui_q) begin
          if (rprev == ci_q) cnext_d = rnext;
        end else begin
          cprev_d = rprev;
        end
      end
      default: ;
    endcase

    // per-request flags
    if (cmd_i.start) begin
      cond_b_d = (req_i.kind == KindRelease);
      cond_a_d = 1'b0;
    end
  end

  assign rsp_o.payload_address = (stat_q == StOk) ? paddr_q : 16'd0;
  assign rsp_o.status          = stat_q;
  assign rsp_o.heap_break      = brk_q[16:0];

endmodule

/* hdl/best_fit_heap_allocator.sv */
// best-fit heap allocator: one request walks the block list; a list step passes read,
// wait and evaluate states, one step per block visited plus the end check (a release
// match ends the walk at its block); one request in flight at a time
// the walk over node rams with registered read sets the rate
// async active-low reset: empty list, break 0, header 16
// depends on bfha_pkg, bfha_ctrl, bfha_dp, bfha_ram
module best_fit_heap_allocator #(
  parameter int unsigned NumNodes  = bfha_pkg::NumNodesDef,
  parameter int unsigned HeapBytes = bfha_pkg::HeapBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [6:0]     cfg_data_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bfha_pkg::req_t req_data_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output bfha_pkg::rsp_t rsp_data_o
);
  import bfha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bfha_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_kind_i(req_data_i.kind),
    .rsp_valid_o, .rsp_ready_i, .cmd_o(cmd), .sts_i(sts));

  bfha_dp #(.NumNodes(NumNodes), .HeapBytes(HeapBytes)) u_dp (
    .clk_i, .rst_ni, .cfg_valid_i(cfg_valid_i & cfg_ready_o), .cfg_data_i,
    .req_i(req_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp_data_o));

endmodule

/* hdl/bfha_chk.sv */
// port-level checker for the allocator, bound to the top level
// depends on bfha_pkg
module bfha_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input bfha_pkg::rsp_t rsp_data_o
);
  import bfha_pkg::*;

  // a result beat holds while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_data_o))
    else $error("result beat changed while stalled");

  // no new request while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken with result pending");

  // failed status gives zero address
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_data_o.status != StOk |-> rsp_data_o.payload_address == 16'd0)
    else $error("address on failed request");

  // accepted request gets no immediate result
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !rsp_valid_o)
    else $error("result too early");

endmodule

bind best_fit_heap_allocator bfha_chk u_chk (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_data_o);

/* tb/sv/tb_best_fit_heap_allocator.sv */
// self-checking testbench for best_fit_heap_allocator
// drives request and config beats, expects block-list model or typed-in responses
// depends on bfha_pkg and the allocator rtl
module tb_best_fit_heap_allocator;
  import bfha_pkg::*;

  localparam int unsigned Nodes = 64;
  localparam int unsigned NoNode = Nodes;
  localparam int unsigned DrainCycles = 3 * Nodes + 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i = '0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_data_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_data_o;

  best_fit_heap_allocator dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .req_valid_i, .req_ready_o, .req_data_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_data_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the heap: address-ordered block list
  int unsigned blk_size [Nodes];
  bit          blk_used [Nodes];
  int unsigned blk_next [Nodes];
  int unsigned blk_prev [Nodes];
  bit          node_busy [Nodes];
  int unsigned first_blk = NoNode;
  int unsigned last_blk = NoNode;
  int unsigned heap_end = 0;
  int unsigned hdr_bytes = 16;

  rsp_t pending_rsp [$];
  bit   failed = 1'b0;
  bit   quiet = 1'b0;
  bit   hold_rsp = 1'b0;
  int   rsp_stall = 0;

  function automatic int unsigned grab_node();
    for (int unsigned k = 0; k < Nodes; k++) begin
      if (!node_busy[k]) begin
        node_busy[k] = 1'b1;
        return k;
      end
    end
    return NoNode;
  endfunction

  function automatic bit node_left();
    foreach (node_busy[k]) if (!node_busy[k]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_blk(int unsigned k);
    int unsigned p, n;
    p = blk_prev[k];
    n = blk_next[k];
    if (p != NoNode) blk_next[p] = n; else first_blk = n;
    if (n != NoNode) blk_prev[n] = p; else last_blk = p;
    node_busy[k] = 1'b0;
  endfunction

  // best-fit allocation with split, else append at the break
  function automatic void heap_alloc(int unsigned bytes, ref rsp_t r);
    int unsigned need, k, off, cnt, best, best_off, exact, exact_off, rem, j, n;
    need = bytes + hdr_bytes;
    off = 0;
    cnt = 0;
    best = NoNode;
    best_off = 0;
    exact = NoNode;
    exact_off = 0;
    k = first_blk;
    while (k != NoNode && cnt < Nodes) begin
      if (!blk_used[k]) begin
        if (exact == NoNode && blk_size[k] == need) begin
          exact = k;
          exact_off = off;
        end
        if (blk_size[k] >= need && (best == NoNode || blk_size[k] < blk_size[best])) begin
          best = k;
          best_off = off;
        end
      end
      off += blk_size[k];
      k = blk_next[k];
      cnt++;
    end
    if (exact != NoNode) begin
      if (exact_off + hdr_bytes > 16'hFFFF) begin
        r.status = StNoRoom;
        return;
      end
      blk_used[exact] = 1'b1;
      r.payload_address = 16'(exact_off + hdr_bytes);
      return;
    end
    if (best != NoNode) begin
      rem = blk_size[best] - need;
      if (best_off + hdr_bytes > 16'hFFFF) begin
        r.status = StNoRoom;
        return;
      end
      if (rem > hdr_bytes && node_left()) begin
        j = grab_node();
        n = blk_next[best];
        blk_size[j] = rem;
        blk_used[j] = 1'b0;
        blk_prev[j] = best;
        blk_next[j] = n;
        if (n != NoNode) blk_prev[n] = j; else last_blk = j;
        blk_next[best] = j;
        blk_size[best] = need;
      end
      blk_used[best] = 1'b1;
      r.payload_address = 16'(best_off + hdr_bytes);
      return;
    end
    if (longint'(heap_end) + need > 65536 || heap_end + hdr_bytes > 16'hFFFF || !node_left()) begin
      r.status = StNoRoom;
      return;
    end
    k = grab_node();
    blk_size[k] = need;
    blk_used[k] = 1'b1;
    blk_next[k] = NoNode;
    blk_prev[k] = last_blk;
    if (last_blk != NoNode) blk_next[last_blk] = k; else first_blk = k;
    last_blk = k;
    r.payload_address = 16'(heap_end + hdr_bytes);
    heap_end += need;
  endfunction

  // free, merge with free neighbors, trim a free tail
  function automatic void heap_free(int unsigned addr, ref rsp_t r);
    int unsigned k, off, cnt, n, p;
    off = 0;
    cnt = 0;
    k = first_blk;
    while (k != NoNode && cnt < Nodes) begin
      if (blk_used[k] && off + hdr_bytes == addr) break;
      off += blk_size[k];
      k = blk_next[k];
      cnt++;
    end
    if (k == NoNode || cnt >= Nodes) begin
      r.status = StBadAddr;
      return;
    end
    blk_used[k] = 1'b0;
    n = blk_next[k];
    if (n != NoNode && !blk_used[n]) begin
      blk_size[k] += blk_size[n];
      drop_blk(n);
    end
    p = blk_prev[k];
    if (p != NoNode && !blk_used[p]) begin
      blk_size[p] += blk_size[k];
      drop_blk(k);
      k = p;
    end
    if (blk_next[k] == NoNode) begin
      heap_end -= blk_size[k];
      drop_blk(k);
    end
  endfunction

  function automatic rsp_t heap_response(req_t q);
    rsp_t r;
    r = '0;
    if (q.kind == KindRelease) heap_free(q.release_address, r);
    else heap_alloc(q.request_bytes, r);
    r.heap_break = 17'(heap_end);
    return r;
  endfunction

  // payload address of a random live block, or a random address when none
  function automatic logic [15:0] live_address();
    int unsigned addrs [$];
    int unsigned k, off, cnt;
    off = 0;
    cnt = 0;
    k = first_blk;
    while (k != NoNode && cnt < Nodes) begin
      if (blk_used[k]) addrs.push_back(off + hdr_bytes);
      off += blk_size[k];
      k = blk_next[k];
      cnt++;
    end
    if (addrs.size() == 0) return 16'($urandom);
    return 16'(addrs[$urandom_range(0, addrs.size() - 1)]);
  endfunction

  function automatic int pick_gap();
    int unsigned d;
    d = $urandom_range(0, 9);
    if (quiet || d < 6) return 0;
    if (d < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request beat; expectation is typed in or taken from the model
  task automatic send_req(req_t q, bit typed, rsp_t typed_rsp);
    int gap;
    rsp_t r;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_data_i <= q;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    r = heap_response(q);
    pending_rsp.push_back(typed ? typed_rsp : r);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_hdr(logic [6:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    hdr_bytes = v;
  endtask

  // random request mix: alloc_pct percent allocations, big_pct percent large sizes
  task automatic random_phase(int items, int alloc_pct, int big_pct, bit pause_mid);
    req_t q;
    int d;
    for (int n = 0; n < items; n++) begin
      if (pause_mid && n == items / 2) begin
        req_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_rsp.size() != 0) @(posedge clk_i);
      end
      q = '0;
      q.request_bytes = 16'($urandom);
      q.release_address = 16'($urandom);
      if ($urandom_range(0, 99) < alloc_pct) begin
        q.kind = KindAlloc;
        d = $urandom_range(0, 99);
        if (d < big_pct) q.request_bytes = 16'($urandom);
        else if (d < big_pct + 20) q.request_bytes = 16'($urandom_range(0, 4000));
        else q.request_bytes = 16'($urandom_range(0, 200));
      end else begin
        q.kind = KindRelease;
        if ($urandom_range(0, 4) != 0) q.release_address = live_address();
      end
      send_req(q, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, plus a forced hold
  always @(posedge clk_i) begin
    if (hold_rsp) begin
      rsp_ready_i <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_ready_i <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rsp_ready_i <= 1'b0;
      rsp_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      rsp_ready_i <= 1'b1;
    end
  end

  // response check per beat
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing expected: %h", rsp_data_o);
        failed = 1'b1;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_data_o.payload_address !== e.payload_address) begin
          $error("payload_address expected %0d got %0d", e.payload_address,
                 rsp_data_o.payload_address);
          failed = 1'b1;
        end
        if (rsp_data_o.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, rsp_data_o.status);
          failed = 1'b1;
        end
        if (rsp_data_o.heap_break !== e.heap_break) begin
          $error("heap_break expected %0d got %0d", e.heap_break, rsp_data_o.heap_break);
          failed = 1'b1;
        end
      end
    end
  end

  // directed rows
  typedef struct {
    logic        kind;
    logic [15:0] bytes;
    logic [15:0] addr;
    bit          typed;
    rsp_t        rsp;
  } row_t;

  function automatic row_t mk(logic k, int b, int a, bit t = 0, int pa = 0, int st = 0,
                              int br = 0);
    row_t r;
    r.kind = k;
    r.bytes = 16'(b);
    r.addr = 16'(a);
    r.typed = t;
    r.rsp.payload_address = 16'(pa);
    r.rsp.status = 2'(st);
    r.rsp.heap_break = 17'(br);
    return r;
  endfunction

  initial begin
    row_t rows [$];
    req_t q;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state, extremes, exact fit, split, merge and trim
    rows.push_back(mk(KindRelease, 0, 0, 1, 0, StBadAddr, 0));
    rows.push_back(mk(KindAlloc, 0, 0, 1, 16, StOk, 16));
    rows.push_back(mk(KindAlloc, 65535, 0, 1, 0, StNoRoom, 16));
    rows.push_back(mk(KindAlloc, 100, 0, 1, 32, StOk, 132));
    rows.push_back(mk(KindAlloc, 8, 0, 1, 148, StOk, 156));
    rows.push_back(mk(KindRelease, 65535, 65535, 1, 0, StBadAddr, 156));
    rows.push_back(mk(KindRelease, 0, 32, 1, 0, StOk, 156));
    rows.push_back(mk(KindRelease, 0, 32));
    rows.push_back(mk(KindAlloc, 100, 0));
    rows.push_back(mk(KindRelease, 0, 32));
    rows.push_back(mk(KindAlloc, 50, 0));
    rows.push_back(mk(KindAlloc, 10, 0));
    rows.push_back(mk(KindAlloc, 40, 0));
    rows.push_back(mk(KindRelease, 0, 148));
    rows.push_back(mk(KindRelease, 0, 32));
    rows.push_back(mk(KindAlloc, 30000, 0));
    rows.push_back(mk(KindAlloc, 30000, 0));
    rows.push_back(mk(KindAlloc, 30000, 0));
    rows.push_back(mk(KindRelease, 0, 16));
    rows.push_back(mk(KindAlloc, 0, 65535));
    foreach (rows[k]) begin
      q.kind = rows[k].kind;
      q.request_bytes = rows[k].bytes;
      q.release_address = rows[k].addr;
      send_req(q, rows[k].typed, rows[k].rsp);
    end
    drain();

    // random phases over several header settings
    write_hdr(7'd16);
    random_phase(180, 60, 5, 1'b0);
    drain();
    write_hdr(7'd0);
    random_phase(180, 90, 2, 1'b0);
    drain();
    write_hdr(7'd127);
    random_phase(180, 70, 30, 1'b0);
    drain();

    // no idling, and one long receiver hold while requests keep coming
    write_hdr(7'd64);
    quiet = 1'b1;
    fork
      random_phase(180, 60, 5, 1'b0);
      begin
        repeat (200) @(posedge clk_i);
        hold_rsp <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rsp <= 1'b0;
      end
    join
    quiet = 1'b0;
    drain();

    write_hdr(7'($urandom_range(1, 126)));
    random_phase(180, 55, 10, 1'b1);
    drain();

    if (!failed) $display("best_fit_heap_allocator: match");
    else $display("best_fit_heap_allocator: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #30000000;
    $display("best_fit_heap_allocator: mismatch");
    $finish;
  end

endmodule

/* best_fit_heap_allocator.f */
hdl/bfha_pkg.sv
hdl/bfha_ram.sv
hdl/bfha_ctrl.sv
hdl/bfha_dp.sv
hdl/best_fit_heap_allocator.sv
hdl/bfha_chk.sv
tb/sv/tb_best_fit_heap_allocator.sv
